// File: src/tlv_word_buffer_search_macros.svh
// assertion helpers for the tlv word buffer checker
`ifndef TLV_WORD_BUFFER_SEARCH_MACROS_SVH
`define TLV_WORD_BUFFER_SEARCH_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TLVWS_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlvws check failed");

// next-cycle implication, sampled on clk, off during reset
`define TLVWS_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlvws check failed");

`endif

// File: src/tlvws_pkg.sv
package tlvws_pkg;

  // action codes
  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_REWIND = 3'd2;
  localparam logic [2:0] ACT_FIND   = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;
  localparam logic [2:0] ACT_SKIP   = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NF    = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam int unsigned TAG_LEN_W   = 13;
  localparam int unsigned TAG_WORDS_W = 12;
  localparam logic [1:0]  WORD_ROUND  = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } tlvws_state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] word_in;
    logic [15:0] search_key;
    logic [2:0]  search_kind;
  } tlvws_in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [31:0]          word_out;
    logic [TAG_LEN_W-1:0] record_bytes;
  } tlvws_out_t;

  // decoded view of one tag word against the sought key
  typedef struct packed {
    logic                 hit;
    logic                 fits;
    logic [TAG_LEN_W-1:0] len;
  } tlvws_tag_info_t;

endpackage

// File: src/tlvws_ram.sv
module tlvws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/tlvws_tag_eval.sv
module tlvws_tag_eval #(
  parameter int PW = 9
) (
  input  logic [31:0]               tag,
  input  logic [15:0]               key,
  input  logic [2:0]                kind,
  input  logic [PW-1:0]             scan,
  input  logic [PW-1:0]             fill,
  output tlvws_pkg::tlvws_tag_info_t info,
  output logic [PW-1:0]             end_ptr
);

  localparam int EW = ((PW > tlvws_pkg::TAG_WORDS_W) ? PW : tlvws_pkg::TAG_WORDS_W) + 1;

  logic [tlvws_pkg::TAG_LEN_W-1:0]   len;
  logic [tlvws_pkg::TAG_LEN_W:0]     len_rnd;
  logic [tlvws_pkg::TAG_WORDS_W-1:0] words;
  logic [EW-1:0]                     end_full;

  // data words = ceil(len / 4)
  assign len     = tag[28:16];
  assign len_rnd = {1'b0, len} + (tlvws_pkg::TAG_LEN_W + 1)'(tlvws_pkg::WORD_ROUND);
  assign words   = len_rnd[tlvws_pkg::TAG_LEN_W:2];

  // first word past the record: tag plus its data words
  assign end_full = EW'(scan) + EW'(1) + EW'(words);
  assign end_ptr  = end_full[PW-1:0];

  assign info.hit  = (tag[15:0] == key) && (tag[31:29] == kind);
  assign info.fits = (end_full <= EW'(fill));
  assign info.len  = len;

endmodule

// File: src/tlv_word_buffer_search.sv
// tlv word buffer search: word store with a record scanner over tag-length-value records
// results: clear, append, rewind and failing read/skip/find answer in the next cycle
// results: read and skip go through the store read register, then the result register
// throughput: one command per cycle for immediate ops while the block is idle; the store's single read port sets
//   find to one record per cycle, busy stays high while a read result is pending
// reset (rst_n low, synchronous): both pointers cleared, store contents left as they are
module tlv_word_buffer_search #(
  parameter int STORE_WORDS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  tlvws_pkg::tlvws_in_t in_item,
  // result channel, one beat per command, cannot be stalled
  output logic                 out_strobe,
  output tlvws_pkg::tlvws_out_t out_item
);

  localparam int AW = $clog2(STORE_WORDS);
  localparam int PW = $clog2(STORE_WORDS + 1);

  // control state
  tlvws_pkg::tlvws_state_t state_r, state_nxt;
  logic [PW-1:0]           fill_r, fill_nxt;
  logic [PW-1:0]           scan_r, scan_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // payload registers, no reset needed
  logic [2:0]              op_r;
  logic [15:0]             key_r;
  logic [2:0]              kind_r;
  tlvws_pkg::tlvws_out_t   out_r, out_nxt;

  // store port
  logic                    ram_we;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [31:0]             ram_rdata;

  // tag decode of the word just read
  tlvws_pkg::tlvws_tag_info_t tag_info;
  logic [PW-1:0]           end_ptr;

  logic                    accept;
  logic                    avail;
  logic                    scan_op;
  logic [PW-1:0]           scan_inc;
  logic [PW-1:0]           find_next;
  logic                    find_more;

  assign accept   = start && (state_r == tlvws_pkg::S_IDLE);
  assign busy     = (state_r == tlvws_pkg::S_SCAN);
  // scan <= fill always, so scan < fill also keeps the address inside the store
  assign avail    = (scan_r < fill_r);
  assign scan_inc = scan_r + PW'(1);
  assign scan_op  = (in_item.action == tlvws_pkg::ACT_READ) ||
                    (in_item.action == tlvws_pkg::ACT_FIND) ||
                    (in_item.action == tlvws_pkg::ACT_SKIP);

  // a truncated record is not skipped: find goes on at the word after its tag
  assign find_next = tag_info.fits ? end_ptr : scan_inc;
  assign find_more = (find_next < fill_r);

  tlvws_ram #(
    .WIDTH (32),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_item.word_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // during a scan the word on ram_rdata belongs to the address held in scan_r
  tlvws_tag_eval #(
    .PW (PW)
  ) u_tag_eval (
    .tag     (ram_rdata),
    .key     (key_r),
    .kind    (kind_r),
    .scan    (scan_r),
    .fill    (fill_r),
    .info    (tag_info),
    .end_ptr (end_ptr)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlvws_pkg::S_IDLE: begin
        if (accept && scan_op && avail) begin
          state_nxt = tlvws_pkg::S_SCAN;
        end
      end
      tlvws_pkg::S_SCAN: begin
        if (!((op_r == tlvws_pkg::ACT_FIND) && !tag_info.hit && find_more)) begin
          state_nxt = tlvws_pkg::S_IDLE;
        end
      end
      default: state_nxt = tlvws_pkg::S_IDLE;
    endcase
  end

  // pointers, store access and result
  always_comb begin
    fill_nxt      = fill_r;
    scan_nxt      = scan_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = scan_r[AW-1:0];
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    unique case (state_r)
      tlvws_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_item.action)
            tlvws_pkg::ACT_CLEAR: begin
              fill_nxt      = '0;
              scan_nxt      = '0;
              out_valid_nxt = 1'b1;
            end
            tlvws_pkg::ACT_APPEND: begin
              out_valid_nxt = 1'b1;
              if (fill_r == PW'(STORE_WORDS)) begin
                // full: word dropped
                out_nxt.status = tlvws_pkg::STAT_FULL;
              end else begin
                ram_we   = 1'b1;
                fill_nxt = fill_r + PW'(1);
              end
            end
            tlvws_pkg::ACT_REWIND: begin
              scan_nxt      = '0;
              out_valid_nxt = 1'b1;
            end
            tlvws_pkg::ACT_FIND,
            tlvws_pkg::ACT_READ,
            tlvws_pkg::ACT_SKIP: begin
              if (avail) begin
                ram_re = 1'b1;
              end else begin
                // nothing left past the scan pointer
                out_valid_nxt  = 1'b1;
                out_nxt.status = tlvws_pkg::STAT_NF;
              end
            end
            default: begin
              // unused codes: no operation, ok result
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      tlvws_pkg::S_SCAN: begin
        unique case (op_r)
          tlvws_pkg::ACT_READ: begin
            scan_nxt         = scan_inc;
            out_valid_nxt    = 1'b1;
            out_nxt.word_out = ram_rdata;
          end
          tlvws_pkg::ACT_SKIP: begin
            out_valid_nxt        = 1'b1;
            out_nxt.word_out     = ram_rdata;
            out_nxt.record_bytes = tag_info.len;
            if (tag_info.fits) begin
              scan_nxt = end_ptr;
            end else begin
              // truncated record: pointer stays on the tag
              out_nxt.status = tlvws_pkg::STAT_NF;
            end
          end
          tlvws_pkg::ACT_FIND: begin
            if (tag_info.hit) begin
              // stop on the first data word
              scan_nxt             = scan_inc;
              out_valid_nxt        = 1'b1;
              out_nxt.word_out     = ram_rdata;
              out_nxt.record_bytes = tag_info.len;
            end else begin
              scan_nxt = find_next;
              if (find_more) begin
                // fetch the next tag, one record per cycle
                ram_re    = 1'b1;
                ram_raddr = find_next[AW-1:0];
              end else begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = tlvws_pkg::STAT_NF;
              end
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlvws_pkg::S_IDLE;
      fill_r      <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command operands held for the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_item.action;
      key_r  <= in_item.search_key;
      kind_r <= in_item.search_kind;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

endmodule

// File: src/tlvws_checker.sv
`include "tlv_word_buffer_search_macros.svh"

module tlvws_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_strobe,
  input tlvws_pkg::tlvws_out_t out_item
);

  logic accepted;

  assign accepted = start && !busy;

  // status never carries an unused code
  `TLVWS_CHECK(a_status_code, out_strobe, out_item.status <= tlvws_pkg::STAT_FULL)

  // a result beat always lands while the block is free for the next command
  `TLVWS_CHECK(a_beat_not_busy, out_strobe, !busy)

  // every accepted command either answers at once or starts a scan
  `TLVWS_CHECK_NEXT(a_accept_moves, accepted, out_strobe || busy)

  // no result without a command or a scan behind it
  `TLVWS_CHECK(a_no_stray_beat, out_strobe, $past(accepted) || $past(busy))

endmodule

bind tlv_word_buffer_search tlvws_checker u_tlvws_checker (.*);

// File: bench/tlv_word_buffer_search_checker.sv
module tlv_word_buffer_search_checker
  import tlvws_pkg::*;
#(
  parameter int STORE_WORDS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  tlvws_in_t  in_item,
  input  logic       out_strobe,
  input  tlvws_out_t out_item,
  output int         mismatches,
  output int         outstanding
);

  // shadow of the block's store and pointers
  logic [31:0] word_image [STORE_WORDS];
  int unsigned fill_ptr;
  int unsigned scan_ptr;

  tlvws_out_t responses_due[$];
  tlvws_out_t want_beat;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    fill_ptr    = 0;
    scan_ptr    = 0;
  end

  function automatic int unsigned data_words(logic [31:0] tag);
    int unsigned len;
    len = tag[28:16];
    return (len + WORD_ROUND) >> 2;
  endfunction

  function automatic tlvws_out_t execute_command(tlvws_in_t cmd);
    tlvws_out_t  resp;
    logic [31:0] tag;
    int unsigned n;
    logic        hit;
    resp = '0;
    resp.status = STAT_OK;
    case (cmd.action)
      ACT_CLEAR: begin
        fill_ptr = 0;
        scan_ptr = 0;
      end
      ACT_APPEND: begin
        if (fill_ptr >= STORE_WORDS) begin
          resp.status = STAT_FULL;
        end else begin
          word_image[fill_ptr] = cmd.word_in;
          fill_ptr++;
        end
      end
      ACT_REWIND: begin
        scan_ptr = 0;
      end
      ACT_FIND: begin
        resp.status = STAT_NF;
        hit = 1'b0;
        while (!hit && scan_ptr < fill_ptr) begin
          tag = word_image[scan_ptr];
          scan_ptr++;
          if (tag[15:0] == cmd.search_key && tag[31:29] == cmd.search_kind) begin
            hit = 1'b1;
            resp.status = STAT_OK;
            resp.word_out = tag;
            resp.record_bytes = tag[28:16];
          end else begin
            // truncated record: resume right after its tag
            n = data_words(tag);
            if (scan_ptr + n <= fill_ptr) scan_ptr += n;
          end
        end
      end
      ACT_READ: begin
        if (scan_ptr < fill_ptr) begin
          resp.word_out = word_image[scan_ptr];
          scan_ptr++;
        end else begin
          resp.status = STAT_NF;
        end
      end
      ACT_SKIP: begin
        if (scan_ptr < fill_ptr) begin
          tag = word_image[scan_ptr];
          n = data_words(tag) + 1;
          resp.word_out = tag;
          resp.record_bytes = tag[28:16];
          if (scan_ptr + n <= fill_ptr) scan_ptr += n;
          else resp.status = STAT_NF;
        end else begin
          resp.status = STAT_NF;
        end
      end
      default: ;
    endcase
    return resp;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill_ptr = 0;
      scan_ptr = 0;
      responses_due.delete();
    end else begin
      // a result never belongs to a command accepted on the same edge
      if (out_strobe !== 1'b0) begin
        if (responses_due.size() == 0) begin
          flag_mismatch("unexpected beat", out_item.word_out, '0);
        end else begin
          want_beat = responses_due.pop_front();
          if (out_item.status !== want_beat.status)
            flag_mismatch("status", 32'(out_item.status), 32'(want_beat.status));
          if (out_item.word_out !== want_beat.word_out)
            flag_mismatch("word_out", out_item.word_out, want_beat.word_out);
          if (out_item.record_bytes !== want_beat.record_bytes)
            flag_mismatch("record_bytes", 32'(out_item.record_bytes),
                          32'(want_beat.record_bytes));
        end
      end
      if (start && !busy) responses_due.push_back(execute_command(in_item));
    end
    outstanding = responses_due.size();
  end

endmodule

// File: bench/tlv_word_buffer_search_test.sv
module tlv_word_buffer_search_test;
  import tlvws_pkg::*;

  localparam int STORE_WORDS   = 256;
  localparam int RANDOM_BEATS  = 650;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 300;
  // codes the block treats as no-ops
  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  tlvws_in_t  in_item;
  logic       out_strobe;
  tlvws_out_t out_item;
  int         mismatches;
  int         outstanding;

  // stimulus bookkeeping: how full the store is and which tags went in
  int          cycle_count;
  int          beats_sent;
  int          fill_est;
  logic [31:0] known_tags[$];
  bit          no_idle;
  bit          flooded;

  tlv_word_buffer_search #(
    .STORE_WORDS(STORE_WORDS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  tlv_word_buffer_search_checker #(
    .STORE_WORDS(STORE_WORDS)
  ) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // 10 unit clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung block ends the run as a failure
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one command beat: idle for a random gap, then hold start until accepted
  task automatic send_beat(input logic [2:0] act, input logic [31:0] word,
                           input logic [15:0] key, input logic [2:0] kind);
    tlvws_in_t beat;
    int        gap;
    beat.action      = act;
    beat.word_in     = word;
    beat.search_key  = key;
    beat.search_kind = kind;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      // start low, payload scrambled while idle
      start = 1'b0;
      in_item.action      = 3'($urandom);
      in_item.word_in     = $urandom;
      in_item.search_key  = 16'($urandom);
      in_item.search_kind = 3'($urandom);
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_item = beat;
    // accepted at the first rising edge with busy low
    do @(posedge clk); while (busy);
    case (act)
      ACT_CLEAR: begin
        fill_est = 0;
        known_tags.delete();
      end
      ACT_APPEND: if (fill_est < STORE_WORDS) fill_est++;
      default: ;
    endcase
    // no-op codes are not counted toward the random budget
    if (act != ACT_SPARE_LO && act != ACT_SPARE_HI) beats_sent++;
  endtask

  // command with don't-care fields randomized
  task automatic send_op(input logic [2:0] act);
    send_beat(act, $urandom, 16'($urandom), 3'($urandom));
  endtask

  // tag word followed by a number of random data words
  task automatic append_record(input logic [2:0] kind, input logic [15:0] key,
                               input logic [12:0] len, input int data_cnt);
    logic [31:0] tag;
    tag = {kind, len, key};
    send_beat(ACT_APPEND, tag, 16'($urandom), 3'($urandom));
    known_tags.push_back(tag);
    repeat (data_cnt) send_op(ACT_APPEND);
  endtask

  // find mostly aims at a tag that went in, sometimes at anything
  task automatic send_find();
    logic [31:0] tag;
    if (known_tags.size() > 0 && $urandom_range(0, 4) != 0) begin
      tag = known_tags[$urandom_range(0, known_tags.size() - 1)];
      send_beat(ACT_FIND, $urandom, tag[15:0], tag[31:29]);
    end else begin
      send_beat(ACT_FIND, $urandom, 16'($urandom), 3'($urandom));
    end
  endtask

  // records in, then a mix of scans over them
  task automatic run_episode();
    int          len;
    int          data_cnt;
    int          pick;
    logic [15:0] key;
    no_idle = ($urandom_range(0, 3) == 0);
    // keep the store from filling up through accumulation alone
    if (fill_est > 200 || $urandom_range(0, 3) == 0) send_op(ACT_CLEAR);
    repeat ($urandom_range(1, 5)) begin
      // mostly short records, now and then a huge length
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 16);
      data_cnt = (len + 3) / 4;
      // huge lengths get only a few data words, so the record is likely cut short
      if (data_cnt > 6) data_cnt = $urandom_range(0, 3);
      if (known_tags.size() > 0 && $urandom_range(0, 3) == 0)
        key = known_tags[$urandom_range(0, known_tags.size() - 1)][15:0];
      else
        key = 16'($urandom);
      append_record(3'($urandom), key, 13'(len), data_cnt);
      if ($urandom_range(0, 5) == 0) send_op(3'($urandom));
    end
    if ($urandom_range(0, 1) == 1) send_op(ACT_REWIND);
    repeat ($urandom_range(3, 10)) begin
      pick = $urandom_range(0, 15);
      if (pick < 5) send_find();
      else if (pick < 8) send_op(ACT_READ);
      else if (pick < 12) send_op(ACT_SKIP);
      else if (pick < 13) send_op(ACT_REWIND);
      else send_op(3'($urandom));
    end
  endtask

  // fill the whole store with random words, then push past full
  task automatic flood_store();
    int pick;
    no_idle = ($urandom_range(0, 1) == 0);
    while (fill_est < STORE_WORDS) send_op(ACT_APPEND);
    repeat (3) send_op(ACT_APPEND);
    send_op(ACT_REWIND);
    repeat (6) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) send_find();
      else if (pick == 1) send_op(ACT_READ);
      else send_op(ACT_SKIP);
    end
    flooded = 1'b1;
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    beats_sent = 0;
    fill_est   = 0;
    no_idle    = 1'b0;
    flooded    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty store, extremes of tag fields, truncated record
    send_op(ACT_READ);                          // read with nothing stored
    send_op(ACT_SKIP);                          // skip with nothing stored
    send_find();                                // find with nothing stored
    append_record(3'd7, 16'hFFFF, 13'd0, 0);    // top kind and key, zero length
    send_beat(ACT_APPEND, {3'd0, 13'd5, 16'h0000}, 16'h0000, 3'd0);
    known_tags.push_back({3'd0, 13'd5, 16'h0000});
    send_beat(ACT_APPEND, 32'hFFFF_FFFF, 16'hFFFF, 3'd7);
    send_beat(ACT_APPEND, 32'h0000_0000, 16'h0000, 3'd0);
    append_record(3'd3, 16'h1234, 13'h1FFF, 0); // max length, no data behind it
    append_record(3'd1, 16'h00AA, 13'd4, 1);
    // scan passes over the cut-short record and lands on the last one
    send_beat(ACT_FIND, 32'h0, 16'h00AA, 3'd1);
    send_op(ACT_READ);
    send_op(ACT_REWIND);
    send_op(ACT_SKIP);                          // zero-length record
    send_op(ACT_SKIP);                          // two data words
    send_op(ACT_SKIP);                          // truncated, pointer stays
    send_op(ACT_READ);                          // reads the truncated tag
    send_beat(ACT_FIND, 32'hFFFF_FFFF, 16'hBEEF, 3'd5); // runs to the end, misses
    send_op(ACT_SPARE_LO);
    send_op(ACT_SPARE_HI);
    send_op(ACT_REWIND);
    send_beat(ACT_FIND, 32'h0, 16'hFFFF, 3'd7);
    send_op(ACT_CLEAR);
    send_op(ACT_READ);                          // past end after clear

    // random part: structured record traffic plus one full-store pass
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (!flooded && beats_sent > 300) flood_store();
      else run_episode();
    end

    @(negedge clk);
    start = 1'b0;
    // drain: every command yields one beat
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/tlvws_pkg.sv
src/tlvws_ram.sv
src/tlvws_tag_eval.sv
src/tlv_word_buffer_search.sv
src/tlvws_checker.sv
bench/tlv_word_buffer_search_checker.sv
bench/tlv_word_buffer_search_test.sv
